FILE: rtl/msl_pkg.sv
// Package for the MOESIF snoop line controller.
// Holds the line state codes, message codes and the action struct.
// Depends on nothing else.
package msl_pkg;

	localparam int STATE_W = 4;
	localparam int ADDR_W  = 32;
	localparam int ID_W    = 4;
	localparam int MSG_W   = 2;

	localparam logic [STATE_W-1:0] ST_I  = 4'd0;
	localparam logic [STATE_W-1:0] ST_IS = 4'd1;
	localparam logic [STATE_W-1:0] ST_S  = 4'd2;
	localparam logic [STATE_W-1:0] ST_E  = 4'd3;
	localparam logic [STATE_W-1:0] ST_O  = 4'd4;
	localparam logic [STATE_W-1:0] ST_M  = 4'd5;
	localparam logic [STATE_W-1:0] ST_F  = 4'd6;
	localparam logic [STATE_W-1:0] ST_VM = 4'd7;
	localparam logic [STATE_W-1:0] ST_SM = 4'd8;
	localparam logic [STATE_W-1:0] ST_PM = 4'd9;

	localparam logic MODE_PROC  = 1'b0;
	localparam logic MODE_SNOOP = 1'b1;

	localparam logic [MSG_W-1:0] MSG_LOAD  = 2'd0;
	localparam logic [MSG_W-1:0] MSG_STORE = 2'd1;
	localparam logic [MSG_W-1:0] MSG_GETS  = 2'd0;
	localparam logic [MSG_W-1:0] MSG_GETM  = 2'd1;
	localparam logic [MSG_W-1:0] MSG_DATA  = 2'd2;

	typedef struct packed {
		logic                gets;
		logic                getm;
		logic                dproc;
		logic                dbus;
		logic                ashared;
		logic                miss;
		logic                silent;
		logic                err;
		logic [STATE_W-1:0]  next_state;
	} msl_action_t;

endpackage

FILE: rtl/msl_transition.sv
// Combinational transition logic of the MOESIF line controller.
// Maps the current line state and one event to actions and a next state.
// Depends on msl_pkg.
module msl_transition import msl_pkg::*; (
	input  logic [STATE_W-1:0] state,
	input  logic               mode,
	input  logic [MSG_W-1:0]   msg,
	input  logic               shared_in,
	output msl_action_t        action
);

	msl_action_t raw;

	always_comb begin
		raw = '0;
		raw.next_state = state;
		if (mode == MODE_PROC) begin
			if (msg != MSG_LOAD && msg != MSG_STORE) begin
				raw.err = 1'b1;
			end else begin
				unique case (state)
					ST_I: begin
						raw.miss = 1'b1;
						if (msg == MSG_LOAD) begin
							raw.gets = 1'b1;
							raw.next_state = ST_IS;
						end else begin
							raw.getm = 1'b1;
							raw.next_state = ST_PM;
						end
					end
					ST_S: begin
						if (msg == MSG_LOAD) begin
							raw.dproc = 1'b1;
						end else begin
							raw.getm = 1'b1;
							raw.miss = 1'b1;
							raw.next_state = ST_SM;
						end
					end
					ST_O, ST_F: begin
						if (msg == MSG_LOAD) begin
							raw.dproc = 1'b1;
						end else begin
							raw.getm = 1'b1;
							raw.miss = 1'b1;
							raw.next_state = ST_VM;
						end
					end
					ST_E: begin
						raw.dproc = 1'b1;
						if (msg == MSG_STORE) begin
							raw.silent = 1'b1;
							raw.next_state = ST_M;
						end
					end
					ST_M: begin
						raw.dproc = 1'b1;
					end
					default: begin
						raw.err = 1'b1;
					end
				endcase
			end
		end else if (state != ST_I) begin
			if (msg != MSG_GETS && msg != MSG_GETM && msg != MSG_DATA) begin
				raw.err = 1'b1;
			end else begin
				unique case (state)
					ST_IS: begin
						if (msg == MSG_DATA) begin
							raw.dproc = 1'b1;
							raw.next_state = shared_in ? ST_S : ST_E;
						end
					end
					ST_S: begin
						if (msg == MSG_GETS) begin
							raw.ashared = 1'b1;
						end else if (msg == MSG_GETM) begin
							raw.next_state = ST_I;
						end
					end
					ST_E, ST_O, ST_M: begin
						if (msg == MSG_DATA) begin
							raw.err = 1'b1;
						end else begin
							raw.dbus = 1'b1;
							if (msg == MSG_GETS) begin
								raw.ashared = 1'b1;
								if (state == ST_E) begin
									raw.next_state = ST_F;
								end else if (state == ST_M) begin
									raw.next_state = ST_O;
								end
							end else begin
								raw.next_state = ST_I;
							end
						end
					end
					ST_F: begin
						if (msg == MSG_GETS) begin
							raw.ashared = 1'b1;
							raw.dbus = 1'b1;
						end else if (msg == MSG_GETM) begin
							raw.dbus = 1'b1;
							raw.next_state = ST_I;
						end
					end
					ST_VM: begin
						if (msg == MSG_GETS) begin
							raw.ashared = 1'b1;
							raw.dbus = 1'b1;
						end else if (msg == MSG_GETM) begin
							raw.dbus = 1'b1;
							raw.next_state = ST_PM;
						end else begin
							raw.dproc = 1'b1;
							raw.next_state = ST_M;
						end
					end
					ST_SM: begin
						if (msg == MSG_GETS) begin
							raw.ashared = 1'b1;
						end else if (msg == MSG_DATA) begin
							raw.dproc = 1'b1;
							raw.next_state = ST_M;
						end
					end
					ST_PM: begin
						if (msg == MSG_DATA) begin
							raw.dproc = 1'b1;
							raw.next_state = ST_M;
						end
					end
					default: begin
						raw.err = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		if (raw.err) begin
			action = '0;
			action.err = 1'b1;
			action.next_state = state;
		end else begin
			action = raw;
		end
	end

endmodule

FILE: rtl/moesif_snoop_line_controller.sv
// Top level of the MOESIF snoop line controller for one cache line.
// Holds the input register, the line state and the result register.
// Depends on msl_pkg and msl_transition.
//
// Usage:
// Each input transaction on in_valid/in_ready carries either a processor
// request (mode 0: load or store) or a snooped bus message (mode 1: GETS,
// GETM or DATA), with its address, requester id and sampled shared line.
// Every input transaction yields exactly one result transaction on
// out_valid/out_ready: the bus and processor actions, the address and
// destination id that go with them, miss and silent-upgrade pulses, an
// error flag, and the new line state.
// The event is captured in the input register, the transition is
// looked up from it and the line state, and the result is registered.
// One transaction is accepted every cycle while the receiver does not
// stall; the state update between input and result registers sets the rate.
// When the receiver stalls, the result is held and the input register
// still fills, so one more transaction is taken before in_ready drops.
// Reset clears both registers' valid flags and puts the line in I.
module moesif_snoop_line_controller import msl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [MSG_W-1:0]   msg,
	input  logic [ADDR_W-1:0]  addr,
	input  logic [ID_W-1:0]    requester_id,
	input  logic               shared_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               issue_gets,
	output logic               issue_getm,
	output logic               data_to_proc,
	output logic               data_on_bus,
	output logic               assert_shared,
	output logic [ADDR_W-1:0]  out_addr,
	output logic [ID_W-1:0]    dest_id,
	output logic               count_miss,
	output logic               count_silent_upgrade,
	output logic               protocol_error,
	output logic [STATE_W-1:0] line_state
);

	logic               valid_s1;
	logic               mode_s1;
	logic [MSG_W-1:0]   msg_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [ID_W-1:0]    rid_s1;
	logic               shared_s1;

	logic [STATE_W-1:0] state_q;
	logic               out_valid_q;
	msl_action_t        action_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [ID_W-1:0]    dest_id_q;

	msl_action_t        action;
	logic               advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	msl_transition u_transition (
		.state     (state_q),
		.mode      (mode_s1),
		.msg       (msg_s1),
		.shared_in (shared_s1),
		.action    (action)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1   <= mode;
			msg_s1    <= msg;
			addr_s1   <= addr;
			rid_s1    <= requester_id;
			shared_s1 <= shared_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_I;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= action.next_state;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q   <= action;
			out_addr_q <= (action.gets || action.getm || action.dproc || action.dbus)
				? addr_s1 : '0;
			dest_id_q  <= action.dbus ? rid_s1 : '0;
		end
	end

	assign out_valid            = out_valid_q;
	assign issue_gets           = action_q.gets;
	assign issue_getm           = action_q.getm;
	assign data_to_proc         = action_q.dproc;
	assign data_on_bus          = action_q.dbus;
	assign assert_shared        = action_q.ashared;
	assign out_addr             = out_addr_q;
	assign dest_id              = dest_id_q;
	assign count_miss           = action_q.miss;
	assign count_silent_upgrade = action_q.silent;
	assign protocol_error       = action_q.err;
	assign line_state           = action_q.next_state;

endmodule
